@@ rtl/sentence_boundary_tracker_unit_defines.svh @@
// Assertion macros for the sentence boundary tracker.
// Included by the top level; expects clk and rst_n in scope.
`ifndef SENTENCE_BOUNDARY_TRACKER_UNIT_DEFINES_SVH
`define SENTENCE_BOUNDARY_TRACKER_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define SBT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define SBT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/sbt_pkg.sv @@
// Shared types and event codes for the sentence boundary tracker.
// No dependencies; used by sbt_step, sbt_emit and the top level.
`default_nettype none

package sbt_pkg;

  localparam logic [4:0] KIND_WORD         = 5'd0;
  localparam logic [4:0] KIND_ABBREV       = 5'd1;
  localparam logic [4:0] KIND_CONTRACTION  = 5'd2;
  localparam logic [4:0] KIND_SPLIT        = 5'd3;
  localparam logic [4:0] KIND_PUNCT        = 5'd4;
  localparam logic [4:0] KIND_PERIOD       = 5'd5;
  localparam logic [4:0] KIND_OTHER_TERM   = 5'd6;
  localparam logic [4:0] KIND_OPEN_BRACKET = 5'd7;
  localparam logic [4:0] KIND_CLOSE_BRACKET = 5'd8;
  localparam logic [4:0] KIND_AMBIG_DOUBLE = 5'd9;
  localparam logic [4:0] KIND_OPEN_DOUBLE  = 5'd10;
  localparam logic [4:0] KIND_CLOSE_DOUBLE = 5'd11;
  localparam logic [4:0] KIND_AMBIG_SINGLE = 5'd12;
  localparam logic [4:0] KIND_OPEN_SINGLE  = 5'd13;
  localparam logic [4:0] KIND_CLOSE_SINGLE = 5'd14;
  localparam logic [4:0] KIND_MONTH_DAY    = 5'd15;
  localparam logic [4:0] KIND_IGNORE       = 5'd16;
  localparam logic [4:0] KIND_END          = 5'd17;

  typedef struct packed {
    logic in_bracket;
    logic in_double;
    logic in_single;
    logic after_abbrev;
    logic after_close_punct;
    logic terminator_pending;
    logic sentence_open;
  } sbt_state_t;

  typedef struct packed {
    logic [4:0] kind;
    logic       first_upper;
    logic       first_lower;
    logic       touches_previous;
  } sbt_event_t;

  // Outcome of one event: number of results (0..3), break on the first
  // one, and whether the results are token pieces or the bare close.
  typedef struct packed {
    logic [1:0] count;
    logic       brk;
    logic       is_token;
  } sbt_result_t;

endpackage

`default_nettype wire

@@ rtl/sbt_step.sv @@
// Per-event flag update and result summary for the sentence boundary tracker.
// Pure combinational; depends on sbt_pkg.
`default_nettype none

module sbt_step (
  input  sbt_pkg::sbt_state_t  state_i,
  input  sbt_pkg::sbt_event_t  ev_i,
  output sbt_pkg::sbt_state_t  state_o,
  output sbt_pkg::sbt_result_t res_o
);

  // Close the sentence if a terminator is waiting.
  function automatic logic flush_pending(inout sbt_pkg::sbt_state_t s);
    logic b;
    b = s.terminator_pending & s.sentence_open;
    if (s.terminator_pending) begin
      s.sentence_open      = 1'b0;
      s.terminator_pending = 1'b0;
    end
    return b;
  endfunction

  // Append a token; caps break after an abbreviation outside brackets.
  function automatic logic add_token(inout sbt_pkg::sbt_state_t s, input logic caps_up);
    logic b;
    b = caps_up & s.after_abbrev & ~s.in_bracket & s.sentence_open;
    s.after_abbrev      = 1'b0;
    s.after_close_punct = 1'b0;
    s.sentence_open     = 1'b1;
    return b;
  endfunction

  sbt_pkg::sbt_state_t st;
  logic                brk;
  logic [1:0]          cnt;
  logic                tok;
  logic                apos;

  always_comb begin
    st   = state_i;
    brk  = 1'b0;
    cnt  = 2'd0;
    tok  = 1'b1;
    apos = 1'b0;
    unique case (ev_i.kind) inside
      sbt_pkg::KIND_WORD, sbt_pkg::KIND_CONTRACTION: begin
        // lower-case word right after closing punctuation cancels the stop
        if (st.terminator_pending & st.after_close_punct & ev_i.first_lower) begin
          st.terminator_pending = 1'b0;
        end else begin
          brk = flush_pending(st);
        end
        brk = brk | add_token(st, ev_i.first_upper);
        cnt = (ev_i.kind == sbt_pkg::KIND_CONTRACTION) ? 2'd2 : 2'd1;
      end
      sbt_pkg::KIND_ABBREV: begin
        brk = flush_pending(st);
        brk = brk | add_token(st, 1'b0);
        st.after_abbrev = 1'b1;
        cnt = 2'd1;
      end
      sbt_pkg::KIND_SPLIT: begin
        brk = flush_pending(st);
        brk = brk | add_token(st, ev_i.first_upper);
        cnt = 2'd2;
      end
      sbt_pkg::KIND_PUNCT: begin
        st.terminator_pending = 1'b0;
        brk = add_token(st, ev_i.first_upper);
        cnt = 2'd1;
      end
      sbt_pkg::KIND_PERIOD: begin
        brk = add_token(st, ev_i.first_upper);
        if (!st.in_single) begin
          st.terminator_pending = 1'b1;
        end
        cnt = 2'd1;
      end
      sbt_pkg::KIND_OTHER_TERM: begin
        brk = add_token(st, ev_i.first_upper);
        if (!(st.in_bracket | st.in_single)) begin
          st.terminator_pending = 1'b1;
        end
        cnt = 2'd1;
      end
      sbt_pkg::KIND_OPEN_BRACKET: begin
        brk = flush_pending(st);
        brk = brk | add_token(st, ev_i.first_upper);
        st.in_bracket = 1'b1;
        cnt = 2'd1;
      end
      sbt_pkg::KIND_CLOSE_BRACKET: begin
        brk = add_token(st, ev_i.first_upper);
        st.in_bracket        = 1'b0;
        st.after_close_punct = 1'b1;
        cnt = 2'd1;
      end
      sbt_pkg::KIND_AMBIG_DOUBLE, sbt_pkg::KIND_OPEN_DOUBLE,
      sbt_pkg::KIND_CLOSE_DOUBLE: begin
        if (ev_i.kind == sbt_pkg::KIND_CLOSE_DOUBLE ||
            (ev_i.kind == sbt_pkg::KIND_AMBIG_DOUBLE && st.in_double)) begin
          brk = add_token(st, ev_i.first_upper);
          st.in_double         = 1'b0;
          st.after_close_punct = 1'b1;
        end else begin
          brk = flush_pending(st);
          brk = brk | add_token(st, ev_i.first_upper);
          st.in_double = 1'b1;
        end
        cnt = 2'd1;
      end
      sbt_pkg::KIND_AMBIG_SINGLE: begin
        if (st.in_single) begin
          brk = add_token(st, ev_i.first_upper);
          st.in_single         = 1'b0;
          st.after_close_punct = 1'b1;
        end else begin
          // touching a nonempty sentence: apostrophe, not a quote
          brk  = flush_pending(st);
          apos = st.sentence_open & ev_i.touches_previous;
          brk  = brk | add_token(st, ev_i.first_upper);
          st.in_single = ~apos;
        end
        cnt = 2'd1;
      end
      sbt_pkg::KIND_OPEN_SINGLE: begin
        brk = flush_pending(st);
        brk = brk | add_token(st, ev_i.first_upper);
        st.in_single = 1'b1;
        cnt = 2'd1;
      end
      sbt_pkg::KIND_CLOSE_SINGLE: begin
        brk = add_token(st, ev_i.first_upper);
        st.in_single         = 1'b0;
        st.after_close_punct = 1'b1;
        cnt = 2'd1;
      end
      sbt_pkg::KIND_MONTH_DAY: begin
        brk = flush_pending(st);
        brk = brk | add_token(st, ev_i.first_upper);
        st.terminator_pending = 1'b1;
        cnt = 2'd3;
      end
      sbt_pkg::KIND_END: begin
        brk = 1'b1;
        tok = 1'b0;
        cnt = {1'b0, st.sentence_open};
        st  = '0;
      end
      default: begin
        // ignore and unused codes: no result, no change
        cnt = 2'd0;
      end
    endcase
  end

  assign state_o        = st;
  assign res_o.count    = cnt;
  assign res_o.brk      = brk;
  assign res_o.is_token = tok;

endmodule

`default_nettype wire

@@ rtl/sbt_emit.sv @@
// Result register and piece sequencer: plays out one to three results per event.
// Depends on sbt_pkg.
`default_nettype none

module sbt_emit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  sbt_pkg::sbt_result_t res,
  output logic                free,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_is_token,
  output logic [1:0]          out_piece,
  output logic                out_break_before,
  output logic                out_last
);

  logic       valid_r, valid_nxt;
  logic       tok_r, tok_nxt;
  logic [1:0] piece_r, piece_nxt;
  logic       brk_r, brk_nxt;
  logic       last_r, last_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       taken;

  assign taken = valid_r & ~out_stall;
  assign free  = ~valid_r | (taken & last_r);

  always_comb begin
    valid_nxt = valid_r;
    tok_nxt   = tok_r;
    piece_nxt = piece_r;
    brk_nxt   = brk_r;
    last_nxt  = last_r;
    cnt_nxt   = cnt_r;
    if (load) begin
      valid_nxt = 1'b1;
      tok_nxt   = res.is_token;
      piece_nxt = 2'd0;
      brk_nxt   = res.brk;
      last_nxt  = (res.count == 2'd1);
      cnt_nxt   = res.count;
    end else if (taken) begin
      if (last_r) begin
        valid_nxt = 1'b0;
      end else begin
        // later pieces never carry a break
        piece_nxt = piece_r + 2'd1;
        brk_nxt   = 1'b0;
        last_nxt  = ((piece_r + 2'd2) == cnt_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tok_r   <= tok_nxt;
    piece_r <= piece_nxt;
    brk_r   <= brk_nxt;
    last_r  <= last_nxt;
    cnt_r   <= cnt_nxt;
  end

  assign out_valid        = valid_r;
  assign out_is_token     = tok_r;
  assign out_piece        = piece_r;
  assign out_break_before = brk_r;
  assign out_last         = last_r;

endmodule

`default_nettype wire

@@ rtl/sentence_boundary_tracker_unit.sv @@
// Top level of the sentence boundary tracker: input register, flag state,
// step logic (sbt_step) and result sequencer (sbt_emit). Depends on sbt_pkg.
//
//   port group   dir   handshake          payload
//   in_*         in    in_valid/in_stall  kind, first_upper, first_lower,
//                                          touches_previous
//   out_*        out   out_valid/out_stall is_token, piece, break_before, last
//
// One event word enters per cycle while in_stall is low. It is held in the input
// register, then updates the flags and loads the result register in the same cycle.
// An event with one result therefore flows at one word per cycle while out_stall is
// low; contraction and split give two words, month-day three, at the output's pace.
// Ignore, unused codes and end of text on an empty sentence produce no word
// and pass without touching the output side.
// Reset (rst_n low, synchronous) clears all flags and both valid bits.
`default_nettype none

module sentence_boundary_tracker_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [4:0] in_kind,
  input  logic       in_first_upper,
  input  logic       in_first_lower,
  input  logic       in_touches_previous,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_is_token,
  output logic [1:0] out_piece,
  output logic       out_break_before,
  output logic       out_last
);

  // input register
  logic                in_valid_r, in_valid_nxt;
  sbt_pkg::sbt_event_t ev_r, ev_nxt;

  // flags carried between events
  sbt_pkg::sbt_state_t state_r, state_nxt;
  sbt_pkg::sbt_state_t step_state;
  sbt_pkg::sbt_result_t step_res;

  logic in_accept;
  logic emit_free;
  logic advance;
  logic emit_load;

  sbt_step u_step (
    .state_i (state_r),
    .ev_i    (ev_r),
    .state_o (step_state),
    .res_o   (step_res)
  );

  // The held event retires when it makes no word, or when the result
  // register is empty or handing off its final word this cycle.
  assign advance   = in_valid_r & ((step_res.count == 2'd0) | emit_free);
  assign emit_load = advance & (step_res.count != 2'd0);
  assign in_stall  = in_valid_r & ~advance;
  assign in_accept = in_valid & ~in_stall;

  always_comb begin
    in_valid_nxt = in_valid_r;
    ev_nxt       = ev_r;
    state_nxt    = state_r;
    if (advance) begin
      state_nxt    = step_state;
      in_valid_nxt = 1'b0;
    end
    if (in_accept) begin
      in_valid_nxt            = 1'b1;
      ev_nxt.kind             = in_kind;
      ev_nxt.first_upper      = in_first_upper;
      ev_nxt.first_lower      = in_first_lower;
      ev_nxt.touches_previous = in_touches_previous;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      state_r    <= '0;
    end else begin
      in_valid_r <= in_valid_nxt;
      state_r    <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ev_r <= ev_nxt;
  end

  sbt_emit u_emit (
    .clk              (clk),
    .rst_n            (rst_n),
    .load             (emit_load),
    .res              (step_res),
    .free             (emit_free),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_is_token     (out_is_token),
    .out_piece        (out_piece),
    .out_break_before (out_break_before),
    .out_last         (out_last)
  );

`include "sentence_boundary_tracker_unit_defines.svh"

  // Input only backs up behind a busy result register.
  `SBT_ASSERT_NOW(a_stall_needs_busy_out, in_stall, out_valid, "in_stall without pending output")

  // The bare close at end of text is a single, breaking, final word.
  `SBT_ASSERT_NOW(a_bare_close_shape, out_valid && !out_is_token,
    out_piece == 2'd0 && out_last && out_break_before, "malformed end-of-text close")

  // Only the first piece of an event may carry a break.
  `SBT_ASSERT_NOW(a_break_first_piece, out_valid && out_piece != 2'd0, !out_break_before,
    "break on a later piece")

  // A taken non-final piece is followed at once by the next piece.
  `SBT_ASSERT_NEXT(a_piece_follows, out_valid && !out_stall && !out_last,
    out_valid && out_piece == $past(out_piece) + 2'd1, "piece sequence broken")

endmodule

`default_nettype wire

@@ bench/tb.sv @@
// Self-checking bench for sentence_boundary_tracker_unit: feeds classified token words,
// predicts each piece with its sentence-break flag and checks the out_ stream in order.
// Depends on sbt_pkg and the unit's RTL; nothing else.
module tb;

  // Highest value the kind field can carry; codes above KIND_END are unused.
  localparam logic [4:0] KIND_CODE_MAX = '1;

  // One word on the result side, field order as on the ports.
  typedef struct packed {
    logic       is_token;
    logic [1:0] piece;
    logic       break_before;
    logic       last;
  } piece_word_t;

  // Wrapper a random sentence may sit in.
  typedef enum int unsigned {
    WRAP_DOUBLE,
    WRAP_SINGLE,
    WRAP_BRACKET,
    WRAP_NONE
  } wrap_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [4:0] in_kind = sbt_pkg::KIND_WORD;
  logic       in_first_upper = 1'b0;
  logic       in_first_lower = 1'b0;
  logic       in_touches_previous = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_is_token;
  logic [1:0] out_piece;
  logic       out_break_before;
  logic       out_last;

  sbt_pkg::sbt_event_t token_events[$];     // words still to be sent
  piece_word_t         expected_pieces[$];  // predicted results, oldest first
  sbt_pkg::sbt_state_t tracker_flags = '0;  // predictor's copy of the nesting / sentence flags

  int unsigned send_gap_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned queued_items = 0;
  int unsigned mismatch_count = 0;

  sentence_boundary_tracker_unit DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_kind             (in_kind),
    .in_first_upper      (in_first_upper),
    .in_first_lower      (in_first_lower),
    .in_touches_previous (in_touches_previous),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_is_token        (out_is_token),
    .out_piece           (out_piece),
    .out_break_before    (out_break_before),
    .out_last            (out_last)
  );

  always #5 clk = ~clk;

  // Hard stop in case the unit hangs.
  initial begin
    #3_000_000;
    $display("FAIL sentence_boundary_tracker_unit");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // A pending terminator closes the sentence when the next opening token lands.
  function automatic logic flush_terminator();
    logic brk;
    brk = 1'b0;
    if (tracker_flags.terminator_pending) begin
      brk = tracker_flags.sentence_open;
      tracker_flags.sentence_open = 1'b0;
      tracker_flags.terminator_pending = 1'b0;
    end
    return brk;
  endfunction

  // Adds a token to the open sentence. Upper case right after an abbreviation
  // (outside brackets) forces a break when caps checking applies.
  function automatic logic take_token(logic upper, logic caps);
    logic brk;
    brk = 1'b0;
    if (caps && upper && tracker_flags.after_abbrev && !tracker_flags.in_bracket &&
        tracker_flags.sentence_open) begin
      brk = 1'b1;
      tracker_flags.sentence_open = 1'b0;
    end
    tracker_flags.after_abbrev = 1'b0;
    tracker_flags.after_close_punct = 1'b0;
    tracker_flags.sentence_open = 1'b1;
    return brk;
  endfunction

  function automatic void expect_piece(logic is_token, logic [1:0] piece, logic brk);
    piece_word_t w;
    w = {is_token, piece, brk, 1'b0};
    expected_pieces.insert(expected_pieces.size(), w);
  endfunction

  // Works out every result word one accepted event causes; the final one gets last.
  function automatic void predict_pieces(sbt_pkg::sbt_event_t ev);
    int unsigned first_new;
    logic        brk;
    logic        apostrophe;
    first_new = expected_pieces.size();
    brk = 1'b0;
    case (ev.kind)
      sbt_pkg::KIND_WORD, sbt_pkg::KIND_CONTRACTION: begin
        // lower case right after closing punctuation continues the sentence
        if (tracker_flags.terminator_pending && tracker_flags.after_close_punct &&
            ev.first_lower)
          tracker_flags.terminator_pending = 1'b0;
        else
          brk = flush_terminator();
        brk |= take_token(ev.first_upper, 1'b1);
        expect_piece(1'b1, 2'd0, brk);
        if (ev.kind == sbt_pkg::KIND_CONTRACTION)
          expect_piece(1'b1, 2'd1, take_token(1'b0, 1'b1));
      end
      sbt_pkg::KIND_ABBREV: begin
        brk = flush_terminator();
        brk |= take_token(ev.first_upper, 1'b0);
        tracker_flags.after_abbrev = 1'b1;
        expect_piece(1'b1, 2'd0, brk);
      end
      sbt_pkg::KIND_SPLIT: begin
        brk = flush_terminator();
        brk |= take_token(ev.first_upper, 1'b1);
        expect_piece(1'b1, 2'd0, brk);
        expect_piece(1'b1, 2'd1, take_token(1'b0, 1'b1));
      end
      sbt_pkg::KIND_PUNCT: begin
        tracker_flags.terminator_pending = 1'b0;
        expect_piece(1'b1, 2'd0, take_token(ev.first_upper, 1'b1));
      end
      sbt_pkg::KIND_PERIOD: begin
        expect_piece(1'b1, 2'd0, take_token(ev.first_upper, 1'b1));
        if (!tracker_flags.in_single)
          tracker_flags.terminator_pending = 1'b1;
      end
      sbt_pkg::KIND_OTHER_TERM: begin
        expect_piece(1'b1, 2'd0, take_token(ev.first_upper, 1'b1));
        if (!(tracker_flags.in_bracket || tracker_flags.in_single))
          tracker_flags.terminator_pending = 1'b1;
      end
      sbt_pkg::KIND_OPEN_BRACKET: begin
        brk = flush_terminator();
        brk |= take_token(ev.first_upper, 1'b1);
        tracker_flags.in_bracket = 1'b1;
        expect_piece(1'b1, 2'd0, brk);
      end
      sbt_pkg::KIND_CLOSE_BRACKET: begin
        expect_piece(1'b1, 2'd0, take_token(ev.first_upper, 1'b1));
        tracker_flags.in_bracket = 1'b0;
        tracker_flags.after_close_punct = 1'b1;
      end
      sbt_pkg::KIND_AMBIG_DOUBLE, sbt_pkg::KIND_OPEN_DOUBLE,
      sbt_pkg::KIND_CLOSE_DOUBLE: begin
        if (ev.kind == sbt_pkg::KIND_CLOSE_DOUBLE ||
            (ev.kind == sbt_pkg::KIND_AMBIG_DOUBLE && tracker_flags.in_double)) begin
          expect_piece(1'b1, 2'd0, take_token(ev.first_upper, 1'b1));
          tracker_flags.in_double = 1'b0;
          tracker_flags.after_close_punct = 1'b1;
        end else begin
          brk = flush_terminator();
          brk |= take_token(ev.first_upper, 1'b1);
          tracker_flags.in_double = 1'b1;
          expect_piece(1'b1, 2'd0, brk);
        end
      end
      sbt_pkg::KIND_AMBIG_SINGLE: begin
        if (tracker_flags.in_single) begin
          expect_piece(1'b1, 2'd0, take_token(ev.first_upper, 1'b1));
          tracker_flags.in_single = 1'b0;
          tracker_flags.after_close_punct = 1'b1;
        end else begin
          // glued to a nonempty sentence it is an apostrophe, else it opens a quote
          brk = flush_terminator();
          apostrophe = tracker_flags.sentence_open && ev.touches_previous;
          brk |= take_token(ev.first_upper, 1'b1);
          tracker_flags.in_single = !apostrophe;
          expect_piece(1'b1, 2'd0, brk);
        end
      end
      sbt_pkg::KIND_OPEN_SINGLE: begin
        brk = flush_terminator();
        brk |= take_token(ev.first_upper, 1'b1);
        tracker_flags.in_single = 1'b1;
        expect_piece(1'b1, 2'd0, brk);
      end
      sbt_pkg::KIND_CLOSE_SINGLE: begin
        expect_piece(1'b1, 2'd0, take_token(ev.first_upper, 1'b1));
        tracker_flags.in_single = 1'b0;
        tracker_flags.after_close_punct = 1'b1;
      end
      sbt_pkg::KIND_MONTH_DAY: begin
        brk = flush_terminator();
        brk |= take_token(ev.first_upper, 1'b1);
        expect_piece(1'b1, 2'd0, brk);
        expect_piece(1'b1, 2'd1, take_token(1'b0, 1'b1));
        expect_piece(1'b1, 2'd2, take_token(1'b0, 1'b1));
        tracker_flags.terminator_pending = 1'b1;
      end
      sbt_pkg::KIND_END: begin
        // bare close only when the last sentence holds something
        brk = tracker_flags.sentence_open;
        tracker_flags = '0;
        if (brk)
          expect_piece(1'b0, 2'd0, 1'b1);
      end
      default: ;  // ignore and unused codes: no word out, flags untouched
    endcase
    if (expected_pieces.size() > first_new)
      expected_pieces[expected_pieces.size() - 1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: one word from token_events per handshake, random gaps.
  // Valid only drops or changes once the current word has been taken.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : driver
    sbt_pkg::sbt_event_t next_event;
    if (!rst_n) begin
      in_valid <= 1'b0;
      tracker_flags = '0;
    end else begin
      if (in_valid && !in_stall)
        predict_pieces({in_kind, in_first_upper, in_first_lower, in_touches_previous});
      if (!in_valid || !in_stall) begin
        if (token_events.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
          next_event = token_events.pop_front();
          in_valid <= 1'b1;
          in_kind <= next_event.kind;
          in_first_upper <= next_event.first_upper;
          in_first_lower <= next_event.first_lower;
          in_touches_previous <= next_event.touches_previous;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: random stall, in-order compare against expected_pieces.
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string what, piece_word_t want, piece_word_t got);
    string want_s;
    string got_s;
    mismatch_count++;
    if (mismatch_count <= 10) begin
      want_s = $sformatf("is_token=%0b piece=%0d brk=%0b last=%0b", want.is_token,
                         want.piece, want.break_before, want.last);
      got_s = $sformatf("is_token=%0b piece=%0d brk=%0b last=%0b", got.is_token,
                        got.piece, got.break_before, got.last);
      $display("%0t %s: expected %s, got %s", $realtime, what, want_s, got_s);
    end
  endtask

  always @(posedge clk) begin : monitor
    piece_word_t got;
    piece_word_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got = {out_is_token, out_piece, out_break_before, out_last};
        if (expected_pieces.size() == 0) begin
          report_mismatch("word with nothing expected", '0, got);
        end else begin
          want = expected_pieces.pop_front();
          if (got.is_token !== want.is_token || got.piece !== want.piece ||
              got.break_before !== want.break_before || got.last !== want.last)
            report_mismatch("result mismatch", want, got);
        end
      end
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  function automatic void queue_event(logic [4:0] kind, logic up, logic lo, logic touch);
    sbt_pkg::sbt_event_t ev;
    ev = {kind, up, lo, touch};
    token_events.insert(token_events.size(), ev);
    if (kind <= sbt_pkg::KIND_END && kind != sbt_pkg::KIND_IGNORE)
      queued_items++;
  endfunction

  // Random case bits, biased toward lower case; neither and both also occur.
  function automatic void queue_cased(logic [4:0] kind, logic touch);
    int unsigned r;
    r = $urandom_range(0, 7);
    if (r < 4)
      queue_event(kind, 1'b0, 1'b1, touch);
    else if (r < 6)
      queue_event(kind, 1'b1, 1'b0, touch);
    else
      queue_event(kind, r[0], r[0], touch);
  endfunction

  // A plausible sentence: optional wrapper, capitalised start, a random body,
  // terminator with the wrapper closed before or after it.
  function automatic void queue_sentence();
    wrap_t       wrap;
    int unsigned pick;
    logic        close_first;
    wrap = wrap_t'($urandom_range(0, 5) > 3 ? $urandom_range(0, 2) : WRAP_NONE);
    case (wrap)
      WRAP_DOUBLE:  queue_event($urandom_range(0, 1) ? sbt_pkg::KIND_OPEN_DOUBLE
                                                     : sbt_pkg::KIND_AMBIG_DOUBLE,
                                1'b0, 1'b0, 1'($urandom_range(0, 1)));
      WRAP_SINGLE:  queue_event($urandom_range(0, 1) ? sbt_pkg::KIND_OPEN_SINGLE
                                                     : sbt_pkg::KIND_AMBIG_SINGLE,
                                1'b0, 1'b0, $urandom_range(0, 3) == 0);
      WRAP_BRACKET: queue_event(sbt_pkg::KIND_OPEN_BRACKET, 1'b0, 1'b0, 1'b0);
      default: ;
    endcase
    queue_event($urandom_range(0, 3) == 0 ? sbt_pkg::KIND_ABBREV : sbt_pkg::KIND_WORD,
                1'b1, 1'b0, 1'b0);
    repeat ($urandom_range(1, 5)) begin
      pick = $urandom_range(0, 11);
      case (pick)
        0, 1, 2: queue_cased(sbt_pkg::KIND_WORD, 1'b0);
        3: begin
          // abbreviation then a word: upper case may force a break
          queue_event(sbt_pkg::KIND_ABBREV, 1'($urandom_range(0, 1)), 1'b0, 1'b0);
          queue_cased(sbt_pkg::KIND_WORD, 1'b0);
        end
        4: queue_cased(sbt_pkg::KIND_CONTRACTION, 1'b1);
        5: queue_cased(sbt_pkg::KIND_SPLIT, 1'b0);
        6: queue_event(sbt_pkg::KIND_PUNCT, 1'b0, 1'b0, 1'b1);
        7: queue_cased(sbt_pkg::KIND_MONTH_DAY, 1'b0);
        8: queue_event(sbt_pkg::KIND_AMBIG_SINGLE, 1'b0, 1'b0, 1'b1);
        9: begin
          queue_event(sbt_pkg::KIND_OPEN_BRACKET, 1'b0, 1'b0, 1'b0);
          queue_cased(sbt_pkg::KIND_WORD, 1'b1);
          queue_event(sbt_pkg::KIND_OTHER_TERM, 1'b0, 1'b0, 1'b1);
          queue_event(sbt_pkg::KIND_CLOSE_BRACKET, 1'b0, 1'b0, 1'b1);
        end
        10: queue_event(sbt_pkg::KIND_IGNORE, 1'($urandom_range(0, 1)),
                        1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        default: queue_event(sbt_pkg::KIND_OTHER_TERM, 1'b0, 1'b0, 1'b1);
      endcase
    end
    close_first = 1'($urandom_range(0, 1));
    if (!close_first)
      queue_event($urandom_range(0, 3) == 0 ? sbt_pkg::KIND_OTHER_TERM : sbt_pkg::KIND_PERIOD,
                  1'b0, 1'b0, 1'b1);
    case (wrap)
      WRAP_DOUBLE:  queue_event($urandom_range(0, 1) ? sbt_pkg::KIND_CLOSE_DOUBLE
                                                     : sbt_pkg::KIND_AMBIG_DOUBLE,
                                1'b0, 1'b0, 1'b1);
      WRAP_SINGLE:  queue_event($urandom_range(0, 1) ? sbt_pkg::KIND_CLOSE_SINGLE
                                                     : sbt_pkg::KIND_AMBIG_SINGLE,
                                1'b0, 1'b0, 1'b1);
      WRAP_BRACKET: queue_event(sbt_pkg::KIND_CLOSE_BRACKET, 1'b0, 1'b0, 1'b1);
      default: ;
    endcase
    if (close_first)
      queue_event($urandom_range(0, 3) == 0 ? sbt_pkg::KIND_OTHER_TERM : sbt_pkg::KIND_PERIOD,
                  1'b0, 1'b0, 1'b1);
    // lower-case continuation after closing punctuation
    if ($urandom_range(0, 3) == 0)
      queue_cased($urandom_range(0, 1) ? sbt_pkg::KIND_WORD : sbt_pkg::KIND_CONTRACTION,
                  1'b0);
    if ($urandom_range(0, 11) == 0)
      queue_event(sbt_pkg::KIND_END, 1'b0, 1'b0, 1'b0);
  endfunction

  // Mostly sentences; the rest is unconstrained noise over the whole kind range.
  function automatic void fill_until(int unsigned target);
    while (queued_items < target) begin
      if ($urandom_range(0, 99) < 80)
        queue_sentence();
      else
        queue_event(5'($urandom_range(0, KIND_CODE_MAX)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end
  endfunction

  // Sender holds off until every predicted word has come back.
  task automatic wait_drained();
    while (token_events.size() != 0 || in_valid || expected_pieces.size() != 0)
      @(negedge clk);
  endtask

  initial begin
    // directed opening: every event kind except KIND_OPEN_DOUBLE, and the corner rules
    queue_event(sbt_pkg::KIND_ABBREV, 1'b1, 1'b0, 1'b0);
    queue_event(sbt_pkg::KIND_WORD, 1'b1, 1'b0, 1'b0);          // caps after abbreviation
    queue_event(sbt_pkg::KIND_ABBREV, 1'b0, 1'b0, 1'b0);
    queue_event(sbt_pkg::KIND_CONTRACTION, 1'b1, 1'b1, 1'b0);   // both case bits
    queue_event(sbt_pkg::KIND_PERIOD, 1'b0, 1'b0, 1'b1);
    queue_event(sbt_pkg::KIND_CLOSE_DOUBLE, 1'b0, 1'b0, 1'b1);
    queue_event(sbt_pkg::KIND_WORD, 1'b0, 1'b1, 1'b0);          // lower case cancels stop
    queue_event(sbt_pkg::KIND_OPEN_BRACKET, 1'b0, 1'b0, 1'b0);
    queue_event(sbt_pkg::KIND_ABBREV, 1'b1, 1'b0, 1'b0);
    queue_event(sbt_pkg::KIND_WORD, 1'b1, 1'b0, 1'b0);          // no caps break in brackets
    queue_event(sbt_pkg::KIND_OTHER_TERM, 1'b0, 1'b0, 1'b1);
    queue_event(sbt_pkg::KIND_CLOSE_BRACKET, 1'b0, 1'b0, 1'b1);
    queue_event(sbt_pkg::KIND_AMBIG_SINGLE, 1'b0, 1'b0, 1'b1);  // apostrophe
    queue_event(sbt_pkg::KIND_AMBIG_SINGLE, 1'b0, 1'b0, 1'b0);  // opens a quote
    queue_event(sbt_pkg::KIND_PERIOD, 1'b0, 1'b0, 1'b1);        // no stop inside single quote
    queue_event(sbt_pkg::KIND_AMBIG_SINGLE, 1'b1, 1'b1, 1'b1);  // closes
    queue_event(sbt_pkg::KIND_SPLIT, 1'b1, 1'b0, 1'b0);
    queue_event(sbt_pkg::KIND_PUNCT, 1'b0, 1'b0, 1'b1);
    queue_event(sbt_pkg::KIND_MONTH_DAY, 1'b1, 1'b0, 1'b0);     // leaves a stop pending
    queue_event(sbt_pkg::KIND_AMBIG_DOUBLE, 1'b0, 1'b0, 1'b0);  // opens and takes the break
    queue_event(sbt_pkg::KIND_OPEN_SINGLE, 1'b0, 1'b0, 1'b0);
    queue_event(sbt_pkg::KIND_CLOSE_SINGLE, 1'b0, 1'b0, 1'b1);
    queue_event(sbt_pkg::KIND_AMBIG_DOUBLE, 1'b0, 1'b0, 1'b1);  // closes
    queue_event(sbt_pkg::KIND_IGNORE, 1'b1, 1'b1, 1'b1);
    queue_event(KIND_CODE_MAX, 1'b1, 1'b1, 1'b1);               // unused code
    queue_event(sbt_pkg::KIND_END, 1'b0, 1'b0, 1'b0);
    queue_event(sbt_pkg::KIND_END, 1'b1, 1'b1, 1'b1);           // end on an empty sentence

    // busy sender, often-stalling receiver
    send_gap_pct = 13;
    recv_stall_pct = 56;
    fill_until(140);
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    wait_drained();

    // sparse sender, rarely stalling receiver
    send_gap_pct = 56;
    recv_stall_pct = 13;
    fill_until(280);
    wait_drained();

    // full rate both ways
    send_gap_pct = 0;
    recv_stall_pct = 0;
    fill_until(420);
    wait_drained();

    // wait for any stray word after the last expected one
    repeat (8) @(negedge clk);
    if (mismatch_count == 0 && expected_pieces.size() == 0)
      $display("PASS sentence_boundary_tracker_unit");
    else
      $display("FAIL sentence_boundary_tracker_unit");
    $finish;
  end

endmodule
